[rtl/core/pixel_clock_divider_select_assert.svh]
// Assertion macros used by the pixel clock divider select top level.
`ifndef PIXEL_CLOCK_DIVIDER_SELECT_ASSERT_SVH
`define PIXEL_CLOCK_DIVIDER_SELECT_ASSERT_SVH
// Checks that an implication holds at every clock edge outside reset.
`define PCDS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcds assertion failed");
// Checks that a condition holds in the cycle after an antecedent.
`define PCDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcds assertion failed");
`endif

[rtl/core/pcds_pkg.sv]
// Package with types and constants of the pixel clock divider select block.
`default_nettype none
package pcds_pkg;
  localparam int unsigned RateW = 32;
  localparam int unsigned QuoW = 33;
  localparam int unsigned DivW = 36;
  localparam int unsigned NumCells = QuoW;

  typedef enum logic [1:0] {
    MODE_DIVIDER = 2'd0,
    MODE_SEVENTH = 2'd1,
    MODE_NINTH   = 2'd2
  } mode_e;

  typedef enum logic [0:0] {
    REG_MULT_WIDTH  = 1'b0,
    REG_SHIFT_WIDTH = 1'b1
  } reg_idx_e;

  // Payload that travels through the divider row.
  typedef struct packed {
    logic             zero_rate;
    logic [RateW-1:0] rate;
    logic [RateW-1:0] parent;
    logic [3:0]       mult_w;
    logic [4:0]       lmax;
    logic [DivW-1:0]  rem;
    logic [QuoW-1:0]  quo;
  } cell_data_t;
endpackage
`default_nettype wire

[rtl/core/pcds_if.sv]
// Valid/ready channel interface with a generic payload.
`default_nettype none
interface pcds_if #(parameter int unsigned Width = 64) ();
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/pcds_cell.sv]
// One restoring-division cell: produces one quotient bit of parent over rate.
`default_nettype none
module pcds_cell import pcds_pkg::*; #(
  parameter int unsigned Bit = 0
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic       valid_i,
  input  cell_data_t      data_i,
  output logic            valid_o,
  output cell_data_t      data_o
);
  logic            valid_q;
  cell_data_t      data_q, data_d;
  logic [DivW-1:0] trial;
  logic [DivW-1:0] dsh;

  always_comb begin
    data_d = data_i;
    dsh = DivW'(data_i.rate) << Bit;
    trial = data_i.rem - dsh;
    if ((data_i.rem >> Bit) >= DivW'(data_i.rate)) begin
      data_d.rem = trial;
      data_d.quo[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o = data_q;
endmodule
`default_nettype wire

[rtl/core/pcds_select.sv]
// Post-division stages: exponent search, error compare and rate division.
`default_nettype none
module pcds_select import pcds_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  cell_data_t       data_i,
  output logic             valid_o,
  output logic [1:0]       mode_o,
  output logic [7:0]       mfield_o,
  output logic [4:0]       exp_o,
  output logic [RateW-1:0] rrate_o,
  output logic             flag_o
);
  // Stage A: exponent and multiplier.
  logic [QuoW-1:0] total, need;
  logic [4:0]      e_a;
  logic [QuoW-1:0] m_a;
  logic            found;
  logic [8:0]      mmax;

  always_comb begin
    total = data_i.quo;
    mmax = 9'd1 << data_i.mult_w;
    need = (total >> data_i.mult_w) +
           QuoW'((total & QuoW'(mmax - 9'd1)) != '0);
    e_a = data_i.lmax;
    found = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (!found && (5'(i) < data_i.lmax) && ((QuoW'(1) << i) >= need)) begin
        e_a = 5'(i);
        found = 1'b1;
      end
    end
    m_a = total >> e_a;
  end

  logic            va_q;
  logic            za_q;
  logic [RateW-1:0] ra_q, pa_q;
  logic [8:0]      mmax_q;
  logic [4:0]      ea_q;
  logic [QuoW-1:0] ma_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (en_i) va_q <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      za_q <= data_i.zero_rate;
      ra_q <= data_i.rate;
      pa_q <= data_i.parent;
      mmax_q <= mmax;
      ea_q <= e_a;
      ma_q <= m_a;
    end
  end

  // Stage B: products (one multiplier each).
  logic [QuoW-1:0] mshift;
  logic [64:0]     prod_b;
  assign mshift = ma_q << ea_q;
  assign prod_b = 65'(mshift) * 65'(ra_q);

  logic            vb_q, zb_q;
  logic [64:0]     prod_q;
  logic [RateW+3:0] r7_q, r9_q;
  logic [RateW-1:0] pb_q;
  logic [8:0]      mmaxb_q;
  logic [4:0]      eb_q;
  logic [QuoW-1:0] mb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (en_i) vb_q <= va_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zb_q <= za_q;
      prod_q <= prod_b;
      r7_q <= (36'(ra_q) * 36'd7) >> 1;
      r9_q <= (36'(ra_q) * 36'd9) >> 1;
      pb_q <= pa_q;
      mmaxb_q <= mmax_q;
      eb_q <= ea_q;
      mb_q <= ma_q;
    end
  end

  // Stage C: mode choice and multiplier field.
  logic [64:0] v0, v1, v2, p65, r765, r965;
  mode_e       mode_c;
  logic [7:0]  mf_c;
  logic        fl_c;

  always_comb begin
    p65 = 65'(pb_q);
    r765 = 65'(r7_q);
    r965 = 65'(r9_q);
    v0 = (prod_q >= p65) ? prod_q - p65 : p65 - prod_q;
    v1 = (r765 >= p65) ? r765 - p65 : p65 - r765;
    v2 = (r965 >= p65) ? r965 - p65 : p65 - r965;
    mode_c = MODE_DIVIDER;
    if (prod_q != p65) begin
      if (v1 < v0 && v1 < v2) mode_c = MODE_SEVENTH;
      else if (v2 < v0 && v2 < v1) mode_c = MODE_NINTH;
    end
    fl_c = 1'b0;
    if (mb_q == '0) begin
      fl_c = 1'b1;
      mf_c = 8'd0;
    end else if (mb_q > QuoW'(mmaxb_q)) begin
      fl_c = 1'b1;
      mf_c = 8'(mmaxb_q - 9'd1);
    end else begin
      mf_c = 8'(mb_q - QuoW'(1));
    end
  end

  logic            vc_q, zc_q, flc_q;
  mode_e           modec_q;
  logic [7:0]      mfc_q;
  logic [4:0]      ec_q;
  logic [RateW-1:0] pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else if (en_i) vc_q <= vb_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zc_q <= zb_q;
      flc_q <= fl_c;
      modec_q <= mode_c;
      mfc_q <= mf_c;
      ec_q <= eb_q;
      pc_q <= pb_q;
    end
  end

  // Stage D..: rate division, one quotient bit per stage over the parent.
  // The parent is divided by the multiplier, or by 7 or 9 in the fixed modes.
  localparam int unsigned NStg = RateW;
  logic [NStg:0]            dv;
  logic [NStg:0][RateW-1:0] drem, dquo;
  logic [NStg:0][8:0]       ddiv;
  logic [NStg:0][1:0]       dmode;
  logic [NStg:0][7:0]       dmf;
  logic [NStg:0][4:0]       dexp;
  logic [NStg:0]            dfl;

  assign dv[0] = vc_q;
  assign drem[0] = zc_q ? '0 : pc_q;
  assign dquo[0] = '0;
  assign ddiv[0] = zc_q ? 9'd1 :
                   (modec_q == MODE_SEVENTH) ? 9'd7 :
                   (modec_q == MODE_NINTH) ? 9'd9 : 9'(mfc_q) + 9'd1;
  assign dmode[0] = zc_q ? 2'(MODE_DIVIDER) : 2'(modec_q);
  assign dmf[0] = zc_q ? 8'd0 : mfc_q;
  assign dexp[0] = zc_q ? 5'd0 : ec_q;
  assign dfl[0] = zc_q | flc_q;

  for (genvar g = 0; g < NStg; g++) begin : g_div
    localparam int unsigned B = NStg - 1 - g;
    logic [RateW-1:0] rem_d, quo_d;
    always_comb begin
      rem_d = drem[g];
      quo_d = dquo[g];
      if ((41'(drem[g]) >> B) >= 41'(ddiv[g])) begin
        rem_d = RateW'(41'(drem[g]) - (41'(ddiv[g]) << B));
        quo_d[B] = 1'b1;
      end
    end
    logic v_q;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q <= 1'b0;
      else if (en_i) v_q <= dv[g];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        drem[g+1] <= rem_d;
        dquo[g+1] <= quo_d;
        ddiv[g+1] <= ddiv[g];
        dmode[g+1] <= dmode[g];
        dmf[g+1] <= dmf[g];
        dexp[g+1] <= dexp[g];
        dfl[g+1] <= dfl[g];
      end
    end
    assign dv[g+1] = v_q;
  end

  // Final: rounded rate select; the fixed modes double the quotient and
  // take the last bit from the doubled remainder.
  logic rbit;
  assign rbit = ({drem[NStg], 1'b0} >= {24'd0, ddiv[NStg]});
  always_comb begin
    unique case (dmode[NStg]) inside
      MODE_SEVENTH, MODE_NINTH: rrate_o = {dquo[NStg][RateW-2:0], rbit};
      default:                  rrate_o = dquo[NStg] >> dexp[NStg];
    endcase
  end
  assign valid_o = dv[NStg];
  assign mode_o = dmode[NStg];
  assign mfield_o = dmf[NStg];
  assign exp_o = dexp[NStg];
  assign flag_o = dfl[NStg];
endmodule
`default_nettype wire

[rtl/core/pixel_clock_divider_select.sv]
// Pixel clock divider select top level: config registers, division row, output stage.
// Usage: one request transaction on in_if carries the target rate and the
// source clock rate; one result transaction on out_if carries mode_select,
// mult_minus_one, shift_exponent, rounded_rate and out_of_range.
// The total divider is formed by a row of 33 division cells, one quotient bit
// each, followed by three selection stages, a 32-cell rate divider row and
// an output register.
// One request is taken per cycle while the receiver does not stall the output.
// The whole pipeline advances only when the output register is empty or is
// being drained, so a stall of the receiver holds every stage in place and
// in_if.ready falls with it; the output register still frees a slot on the
// cycle it is taken.
// Configuration is written over APB: mult_field_width at 0x0 and
// shift_field_width at 0x4; writes belong to idle periods.
// Reset empties the pipeline and restores widths 8 and 2.
`default_nettype none
module pixel_clock_divider_select import pcds_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  pcds_if.sink             in_if,
  pcds_if.source           out_if
);
  `include "pixel_clock_divider_select_assert.svh"

  logic [3:0] mult_w_q;
  logic [2:0] shift_w_q;
  logic       wr;
  reg_idx_e   widx;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;
  assign widx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_w_q <= 4'd8;
      shift_w_q <= 3'd2;
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (widx)
        REG_MULT_WIDTH:  mult_w_q <= pwdata[3:0];
        REG_SHIFT_WIDTH: shift_w_q <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_MULT_WIDTH:  prdata = {28'd0, mult_w_q};
      REG_SHIFT_WIDTH: prdata = {29'd0, shift_w_q};
      default:         prdata = '0;
    endcase
  end

  logic en;
  logic out_v_q;
  assign en = !out_v_q || out_if.ready;
  assign in_if.ready = en;

  logic [3:0] wc;
  logic [2:0] sc;
  assign wc = (mult_w_q == 4'd0) ? 4'd1 : (mult_w_q > 4'd8) ? 4'd8 : mult_w_q;
  assign sc = (shift_w_q == 3'd0) ? 3'd1 : (shift_w_q > 3'd4) ? 3'd4 : shift_w_q;

  logic [RateW-1:0] t_in, p_in;
  assign t_in = in_if.data[31:0];
  assign p_in = in_if.data[63:32];

  logic [NumCells:0] cv;
  cell_data_t [NumCells:0] cd;
  assign cv[0] = in_if.valid & en;
  always_comb begin
    cd[0].zero_rate = (t_in == '0);
    cd[0].rate = (t_in == '0) ? RateW'(1) : t_in;
    cd[0].parent = p_in;
    cd[0].mult_w = wc;
    cd[0].lmax = 5'd1 << sc;
    cd[0].rem = DivW'(p_in) + DivW'(t_in >> 1);
    cd[0].quo = '0;
  end

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    pcds_cell #(.Bit(NumCells - 1 - g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(cv[g]),
      .data_i (cd[g]),
      .valid_o(cv[g+1]),
      .data_o (cd[g+1])
    );
  end

  logic             sv;
  logic [1:0]       smode;
  logic [7:0]       smf;
  logic [4:0]       sexp;
  logic [RateW-1:0] srr;
  logic             sfl;

  pcds_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cv[NumCells]),
    .data_i  (cd[NumCells]),
    .valid_o (sv),
    .mode_o  (smode),
    .mfield_o(smf),
    .exp_o   (sexp),
    .rrate_o (srr),
    .flag_o  (sfl)
  );

  logic [47:0] out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= sv;
  end
  always_ff @(posedge clk_i) begin
    if (en) out_q <= {sfl, srr, sexp, smf, smode};
  end

  assign out_if.valid = out_v_q;
  assign out_if.data = out_q;

  `PCDS_ASSERT_IMPL(a_stall_blocks, clk_i, rst_ni, out_v_q && !out_if.ready, !in_if.ready)
  `PCDS_ASSERT_NEXT(a_hold_out, clk_i, rst_ni, out_v_q && !out_if.ready, out_v_q && $stable(out_q))
  `PCDS_ASSERT_IMPL(a_mode_legal, clk_i, rst_ni, out_v_q, out_q[1:0] != 2'd3)
endmodule
`default_nettype wire
